[rtl/trcc_pkg.sv]
`timescale 1ns / 1ps

package trcc_pkg;

  localparam int TS_W      = 32;
  localparam int RPM_W     = 16;
  localparam int ADC_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // pot * span numerator width and the full-scale pot divisor
  localparam int MAP_NUM_W = ADC_W + RPM_W;
  localparam int MAP_DIV   = 1023;
  // MAP_DIV is 2**MAP_SH - 1, so the quotient comes from a shift-add estimate
  localparam int MAP_SH    = 10;
  localparam int SEC_PER_MIN = 60;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ENGAGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_ENGAGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIS_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIS_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_MAX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HYST          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd7;

  // register reset values
  localparam logic [RPM_W-1:0] RST_NORMAL_ENGAGE = 16'd1700;
  localparam logic [RPM_W-1:0] RST_KICK_ENGAGE   = 16'd1200;
  localparam logic [RPM_W-1:0] RST_DIS_MIN       = 16'd2200;
  localparam logic [RPM_W-1:0] RST_DIS_MAX       = 16'd2800;
  localparam logic [RPM_W-1:0] RST_SAFE_MAX      = 16'd3000;
  localparam logic [RPM_W-1:0] RST_HYST          = 16'd120;
  localparam logic [RPM_W-1:0] RST_MARGIN        = 16'd60;
  localparam logic [TS_W-1:0]  RST_TIMEOUT       = 32'd240000;

  localparam logic [RPM_W-1:0] RPM_MAX = '1;

  typedef logic [RPM_W-1:0] rpm_t;
  typedef logic [TS_W-1:0]  ts_t;
  typedef logic [ADC_W-1:0] adc_t;

endpackage

[rtl/tooth_rpm_clutch_controller.sv]
`timescale 1ns / 1ps

// Accept to result valid: a tooth edge goes to S_OUT; a control update runs S_MAP_MUL,
// S_MAP_EST, S_MAP_FIX, S_MAP_END, then S_RPM_MUL, S_DIV (27 restoring divider steps),
// S_RPM_END and S_FSTEP if a new period is pending, then S_TMO, S_CLUTCH and S_OUT. One
// request at a time: in_ready drops after accept and returns as the result register loads.
// Reset (rst_n low, synchronous): config to defaults, control state clears, no result.
module tooth_rpm_clutch_controller #(
  parameter int TOOTH_COUNT    = 66,
  parameter int TICK_RATE_HZ   = 2000000,
  parameter int FILTER_SHIFT   = 2,
  parameter int KICK_THRESHOLD = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [trcc_pkg::TS_W-1:0]         in_timestamp,
  input  logic [trcc_pkg::ADC_W-1:0]        in_pot_adc,
  input  logic [trcc_pkg::ADC_W-1:0]        in_kickdown_adc,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [trcc_pkg::RPM_W-1:0]        out_filtered_rpm,
  output logic [trcc_pkg::RPM_W-1:0]        out_dis_thresh,
  output logic                              out_kick_on,
  output logic                              out_clutch_enable,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trcc_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import trcc_pkg::*;

  localparam longint unsigned NUM_C = 64'(TICK_RATE_HZ) * 64'(SEC_PER_MIN);
  localparam int NUM_W = $clog2(NUM_C + 1);
  localparam int DN_W  = (NUM_W > MAP_NUM_W) ? NUM_W : MAP_NUM_W;
  localparam int TW    = $clog2(TOOTH_COUNT + 1);
  localparam int DEN_W = TS_W + TW;
  localparam int CNT_W = $clog2(DN_W);
  localparam int PROD_W = TS_W + RPM_W;
  localparam int MS_W  = MAP_NUM_W + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MAP_MUL = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_MAP_END = 4'd3;
  localparam logic [3:0] S_RPM_MUL = 4'd4;
  localparam logic [3:0] S_RPM_END = 4'd5;
  localparam logic [3:0] S_FSTEP   = 4'd6;
  localparam logic [3:0] S_TMO     = 4'd7;
  localparam logic [3:0] S_CLUTCH  = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;
  localparam logic [3:0] S_MAP_EST = 4'd10;
  localparam logic [3:0] S_MAP_FIX = 4'd11;

  logic [3:0] state_r, state_nxt;

  // configuration
  rpm_t normal_engage_r, kick_engage_r, dis_min_r, dis_max_r;
  rpm_t safe_max_r, hyst_r, margin_r;
  ts_t  timeout_r;

  // block state
  ts_t  last_pulse_r, last_pulse_nxt;
  ts_t  pending_r, pending_nxt;
  logic pend_flag_r, pend_flag_nxt;
  rpm_t filt_r, filt_nxt;
  logic clutch_r, clutch_nxt;
  rpm_t last_dis_r, last_dis_nxt;
  logic last_kd_r, last_kd_nxt;

  // per-update work registers
  ts_t  ts_r, ts_nxt;
  adc_t pot_r, pot_nxt;
  logic kd_r, kd_nxt;
  rpm_t dis_r, dis_nxt;
  rpm_t rpm_r, rpm_nxt;

  // shared multiplier and divider
  logic [DN_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DN_W-1:0]  quot_r, quot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  rpm_t out_rpm_r, out_rpm_nxt;
  rpm_t out_dis_r, out_dis_nxt;
  logic out_kd_r, out_kd_nxt;
  logic out_cl_r, out_cl_nxt;

  logic [TS_W-1:0]   mul_a;
  logic [RPM_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [DEN_W:0]    trial;
  logic              trial_ge;
  rpm_t              span;
  logic [MS_W-1:0]   map_sum, map_rem;
  logic              map_fix;
  logic [RPM_W:0]    dsum;
  logic signed [RPM_W+1:0] delta, fstep, fsum;
  ts_t               period, age;
  rpm_t              engage, release_lvl, upper;
  logic [RPM_W:0]    rpm_margin;
  logic              in_acc, out_load;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;

  assign out_valid           = out_valid_r;
  assign out_filtered_rpm    = out_rpm_r;
  assign out_dis_thresh      = out_dis_r;
  assign out_kick_on         = out_kd_r;
  assign out_clutch_enable   = out_cl_r;

  assign span  = (dis_max_r > dis_min_r) ? rpm_t'(dis_max_r - dis_min_r) : '0;
  assign mul_a = (state_r == S_RPM_MUL) ? pending_r : TS_W'(pot_r);
  assign mul_b = (state_r == S_RPM_MUL) ? RPM_W'(TOOTH_COUNT) : span;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign trial    = {rem_r, num_r[DN_W-1]};
  assign trial_ge = (trial >= {1'b0, den_r});

  // x / 1023 from x * (1 + 2^-10 + 2^-20) / 2^10: low by at most one, then one fixup
  assign map_sum = MS_W'(num_r[MAP_NUM_W-1:0]) + MS_W'(num_r[MAP_NUM_W-1:MAP_SH]) +
                   MS_W'(num_r[MAP_NUM_W-1:2*MAP_SH]);
  assign map_rem = MS_W'(num_r[MAP_NUM_W-1:0]) - (MS_W'(quot_r[RPM_W-1:0]) << MAP_SH) +
                   MS_W'(quot_r[RPM_W-1:0]);
  assign map_fix = (map_rem >= MS_W'(MAP_DIV));

  assign period = in_timestamp - last_pulse_r;
  assign age    = ts_r - last_pulse_r;
  assign dsum   = {1'b0, dis_min_r} + {1'b0, quot_r[RPM_W-1:0]};

  assign delta = $signed({2'b00, rpm_r}) - $signed({2'b00, filt_r});
  assign fstep = delta >>> FILTER_SHIFT;
  assign fsum  = $signed({2'b00, filt_r}) + fstep;

  assign engage      = kd_r ? kick_engage_r : normal_engage_r;
  assign release_lvl = (engage > hyst_r) ? rpm_t'(engage - hyst_r) : '0;
  assign upper       = (dis_r > safe_max_r) ? safe_max_r : dis_r;
  assign rpm_margin  = {1'b0, filt_r} + {1'b0, margin_r};

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    last_pulse_nxt = last_pulse_r;
    pending_nxt    = pending_r;
    pend_flag_nxt  = pend_flag_r;
    filt_nxt       = filt_r;
    clutch_nxt     = clutch_r;
    last_dis_nxt   = last_dis_r;
    last_kd_nxt    = last_kd_r;
    ts_nxt         = ts_r;
    pot_nxt        = pot_r;
    kd_nxt         = kd_r;
    dis_nxt        = dis_r;
    rpm_nxt        = rpm_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    quot_nxt       = quot_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rpm_nxt    = out_rpm_r;
    out_dis_nxt    = out_dis_r;
    out_kd_nxt     = out_kd_r;
    out_cl_nxt     = out_cl_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_opcode) begin
            last_pulse_nxt = in_timestamp;
            if (period != '0) begin
              pending_nxt   = period;
              pend_flag_nxt = 1'b1;
            end
            state_nxt = S_OUT;
          end else begin
            ts_nxt    = in_timestamp;
            pot_nxt   = in_pot_adc;
            kd_nxt    = (in_kickdown_adc >= ADC_W'(KICK_THRESHOLD));
            state_nxt = S_MAP_MUL;
          end
        end
      end
      S_MAP_MUL: begin
        num_nxt   = DN_W'(prod[MAP_NUM_W-1:0]);
        state_nxt = S_MAP_EST;
      end
      S_MAP_EST: begin
        quot_nxt  = DN_W'(map_sum[MS_W-1:MAP_SH]);
        state_nxt = S_MAP_FIX;
      end
      S_MAP_FIX: begin
        quot_nxt  = quot_r + DN_W'(map_fix);
        state_nxt = S_MAP_END;
      end
      S_DIV: begin
        rem_nxt  = trial_ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        num_nxt  = {num_r[DN_W-2:0], 1'b0};
        quot_nxt = {quot_r[DN_W-2:0], trial_ge};
        if (cnt_r == '0) begin
          state_nxt = S_RPM_END;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MAP_END: begin
        dis_nxt   = dsum[RPM_W] ? RPM_MAX : dsum[RPM_W-1:0];
        state_nxt = pend_flag_r ? S_RPM_MUL : S_TMO;
      end
      S_RPM_MUL: begin
        num_nxt       = DN_W'(NUM_C);
        den_nxt       = prod[DEN_W-1:0];
        rem_nxt       = '0;
        quot_nxt      = '0;
        cnt_nxt       = CNT_W'(DN_W - 1);
        state_nxt     = S_DIV;
      end
      S_RPM_END: begin
        rpm_nxt   = (quot_r > DN_W'(RPM_MAX)) ? RPM_MAX : quot_r[RPM_W-1:0];
        state_nxt = S_FSTEP;
      end
      S_FSTEP: begin
        pend_flag_nxt = 1'b0;
        filt_nxt      = (filt_r == '0) ? rpm_r : fsum[RPM_W-1:0];
        state_nxt     = S_TMO;
      end
      S_TMO: begin
        // drop the filter once the last edge is stale
        if (age > timeout_r) begin
          filt_nxt = '0;
        end
        state_nxt = S_CLUTCH;
      end
      S_CLUTCH: begin
        if (clutch_r) begin
          if (filt_r >= safe_max_r || filt_r >= upper || filt_r < release_lvl) begin
            clutch_nxt = 1'b0;
          end
        end else if (filt_r >= engage && filt_r < safe_max_r &&
                     rpm_margin < {1'b0, upper}) begin
          clutch_nxt = 1'b1;
        end
        last_dis_nxt = dis_r;
        last_kd_nxt  = kd_r;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_rpm_nxt   = filt_r;
          out_dis_nxt   = last_dis_r;
          out_kd_nxt    = last_kd_r;
          out_cl_nxt    = clutch_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      last_pulse_r    <= '0;
      pending_r       <= '0;
      pend_flag_r     <= 1'b0;
      filt_r          <= '0;
      clutch_r        <= 1'b0;
      last_dis_r      <= '0;
      last_kd_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      cnt_r           <= '0;
      normal_engage_r <= RST_NORMAL_ENGAGE;
      kick_engage_r   <= RST_KICK_ENGAGE;
      dis_min_r       <= RST_DIS_MIN;
      dis_max_r       <= RST_DIS_MAX;
      safe_max_r      <= RST_SAFE_MAX;
      hyst_r          <= RST_HYST;
      margin_r        <= RST_MARGIN;
      timeout_r       <= RST_TIMEOUT;
    end else begin
      state_r      <= state_nxt;
      last_pulse_r <= last_pulse_nxt;
      pending_r    <= pending_nxt;
      pend_flag_r  <= pend_flag_nxt;
      filt_r       <= filt_nxt;
      clutch_r     <= clutch_nxt;
      last_dis_r   <= last_dis_nxt;
      last_kd_r    <= last_kd_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NORMAL_ENGAGE: normal_engage_r <= cfg_data[RPM_W-1:0];
          REG_KICK_ENGAGE:   kick_engage_r   <= cfg_data[RPM_W-1:0];
          REG_DIS_MIN:       dis_min_r       <= cfg_data[RPM_W-1:0];
          REG_DIS_MAX:       dis_max_r       <= cfg_data[RPM_W-1:0];
          REG_SAFE_MAX:      safe_max_r      <= cfg_data[RPM_W-1:0];
          REG_HYST:          hyst_r          <= cfg_data[RPM_W-1:0];
          REG_MARGIN:        margin_r        <= cfg_data[RPM_W-1:0];
          REG_TIMEOUT:       timeout_r       <= cfg_data[TS_W-1:0];
          default:           timeout_r       <= timeout_r;
        endcase
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    ts_r      <= ts_nxt;
    pot_r     <= pot_nxt;
    kd_r      <= kd_nxt;
    dis_r     <= dis_nxt;
    rpm_r     <= rpm_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    quot_r    <= quot_nxt;
    out_rpm_r <= out_rpm_nxt;
    out_dis_r <= out_dis_nxt;
    out_kd_r  <= out_kd_nxt;
    out_cl_r  <= out_cl_nxt;
  end

endmodule

[rtl/trcc_checker.sv]
`timescale 1ns / 1ps

module trcc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_opcode,
  input logic [trcc_pkg::TS_W-1:0]       in_timestamp,
  input logic [trcc_pkg::ADC_W-1:0]      in_pot_adc,
  input logic [trcc_pkg::ADC_W-1:0]      in_kickdown_adc,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [trcc_pkg::RPM_W-1:0]      out_filtered_rpm,
  input logic [trcc_pkg::RPM_W-1:0]      out_dis_thresh,
  input logic                            out_kick_on,
  input logic                            out_clutch_enable,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [trcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [trcc_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import trcc_pkg::*;

  // a waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_rpm) &&
      $stable(out_dis_thresh) && $stable(out_kick_on) &&
      $stable(out_clutch_enable))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // a new result appears exactly as the block goes idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while still busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |-> !in_ready && !cfg_ready)
    else $error("ready high during reset");

endmodule

bind tooth_rpm_clutch_controller trcc_checker u_trcc_checker (.*);
